/* src/sync_length_checksum_deframer_assert.svh */
// assertion macros used by the checker file
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SLCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcd check failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define SLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcd check failed: next-cycle implication");

`endif

/* src/slcd_pkg.sv */
package slcd_pkg;

  localparam int PAYLOAD_DEPTH_DEFAULT = 256;

  // command codes carried in s_tuser
  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // register indexes, taken from paddr[2]
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

  // bit positions in m_tuser
  localparam int TUSER_GOOD = 0;
  localparam int TUSER_BAD  = 1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

endpackage

/* src/slcd_payload_ram.sv */
module slcd_payload_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/sync_length_checksum_deframer.sv */
// Frame parser for a byte stream laid out as: sync byte one, sync byte two,
// class, id, length, payload (max(length, 1) bytes), 8-bit additive checksum.
// Input channel s_*: s_tuser selects receive (rx_byte in s_tdata[7:0]) or a
// read of the payload store (read_index in s_tdata[15:8]). Every input
// transaction yields exactly one result on m_*: good/bad flags in m_tuser,
// latest class/id/length, last good checksum and the read byte in m_tdata.
// Sync byte values come from two APB registers (0x0 and 0x4); the user must
// write them only while the block is idle, which the block does not enforce.
// The result register and the payload RAM read register load at the
// accepting edge. Throughput is one transaction per cycle unless a held
// result stalls the input; the single-port-per-side payload RAM does one
// write (payload byte) or one read (read command) per transaction.
// When m_tready is low the result holds and s_tready drops until it is
// taken. Synchronous reset returns the parser to the first sync hunt, clears
// header registers and restores the default sync values; the payload RAM is
// not cleared and its unwritten entries read as anything.
module sync_length_checksum_deframer #(
  parameter int PAYLOAD_DEPTH = slcd_pkg::PAYLOAD_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [slcd_pkg::IN_DATA_W-1:0]  s_tdata,  // rx_byte, read_index
  input  logic                            s_tuser,  // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slcd_pkg::OUT_DATA_W-1:0] m_tdata,  // class, id, length, checksum, read_data
  output logic [slcd_pkg::OUT_USER_W-1:0] m_tuser,  // frame_good, frame_bad
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import slcd_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [8:0] DEPTH_9 = 9'(PAYLOAD_DEPTH);

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN, PH_PAYLOAD, PH_CHECK
  } phase_t;

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  phase_t     phase;
  logic [7:0] write_position;
  logic [7:0] length_seen;
  logic [7:0] running_sum;
  logic [7:0] class_reg;
  logic [7:0] id_reg;
  logic [7:0] checksum_reg;

  logic       res_valid;
  logic       res_good;
  logic       res_bad;
  logic       res_read;

  logic       accept;
  logic       is_rx;
  logic [7:0] rx_byte;
  logic [7:0] read_index;
  logic       wr_en;
  logic       rd_en;
  logic       last_byte;
  logic [7:0] sum_next;
  logic [7:0] rd_data;
  logic       cfg_wr;

  assign rx_byte    = s_tdata[7:0];
  assign read_index = s_tdata[15:8];
  assign s_tready   = !rst && (!res_valid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign is_rx      = (s_tuser == CMD_RECEIVE);

  assign sum_next  = running_sum + rx_byte;
  assign last_byte = ({1'b0, write_position} + 9'd1) >= {1'b0, length_seen};
  assign wr_en     = accept && is_rx && (phase == PH_PAYLOAD)
                     && ({1'b0, write_position} < DEPTH_9);
  assign rd_en     = accept && !is_rx && ({1'b0, read_index} < DEPTH_9);

  slcd_payload_ram #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_position[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (read_index[AW-1:0]),
    .rd_data (rd_data)
  );

  // parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      write_position <= '0;
      length_seen    <= '0;
      running_sum    <= '0;
      class_reg      <= '0;
      id_reg         <= '0;
      checksum_reg   <= '0;
      res_valid      <= 1'b0;
      res_good       <= 1'b0;
      res_bad        <= 1'b0;
      res_read       <= 1'b0;
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        res_good  <= 1'b0;
        res_bad   <= 1'b0;
        res_read  <= rd_en;
        if (is_rx) begin
          unique case (phase)
            PH_SYNC1: begin
              if (rx_byte == sync_first) phase <= PH_SYNC2;
            end
            PH_SYNC2: begin
              // a wrong second byte keeps waiting here
              if (rx_byte == sync_second) phase <= PH_CLASS;
            end
            PH_CLASS: begin
              class_reg <= rx_byte;
              phase     <= PH_ID;
            end
            PH_ID: begin
              id_reg <= rx_byte;
              phase  <= PH_LEN;
            end
            PH_LEN: begin
              length_seen    <= rx_byte;
              write_position <= '0;
              running_sum    <= '0;
              phase          <= PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              running_sum    <= sum_next;
              write_position <= write_position + 8'd1;
              if (last_byte) phase <= PH_CHECK;
            end
            PH_CHECK: begin
              if (running_sum == rx_byte) begin
                checksum_reg <= rx_byte;
                res_good     <= 1'b1;
              end else begin
                res_bad <= 1'b1;
              end
              phase          <= PH_SYNC1;
              write_position <= '0;
              running_sum    <= '0;
            end
            default: begin
              phase          <= PH_SYNC1;
              write_position <= '0;
              running_sum    <= '0;
            end
          endcase
        end
      end
    end
  end

  // header registers only change on an accept, so they stay aligned with the result
  assign m_tvalid = res_valid;
  assign m_tdata  = {(res_read ? rd_data : 8'h00), checksum_reg, length_seen, id_reg,
                     class_reg};
  always_comb begin
    m_tuser             = '0;
    m_tuser[TUSER_GOOD] = res_good;
    m_tuser[TUSER_BAD]  = res_bad;
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC_FIRST:  prdata = {24'h0, sync_first};
      REG_SYNC_SECOND: prdata = {24'h0, sync_second};
      default:         prdata = '0;
    endcase
  end

endmodule

/* src/slcd_checker.sv */
`include "sync_length_checksum_deframer_assert.svh"

module slcd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [slcd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [slcd_pkg::OUT_USER_W-1:0] m_tuser
);
  import slcd_pkg::*;

  // a checksum byte is either good or bad, never both
  `SLCD_ASSERT_IMPLY(a_flags_exclusive, clk, rst, m_tvalid, !(m_tuser[TUSER_GOOD] && m_tuser[TUSER_BAD]))

  // stalled result holds
  `SLCD_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // an empty result register never blocks the input
  `SLCD_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // a receive transaction shows up next cycle with zero read byte and no read side effects
  `SLCD_ASSERT_NEXT(a_receive_read_zero, clk, rst, s_tvalid && s_tready && (s_tuser == CMD_RECEIVE), m_tvalid && (m_tdata[39:32] == 8'h00))

  // reset empties the result register
  `SLCD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slcd_pkg::*;

  localparam int ITEMS_PER_SETTING = 205;
  localparam int NUM_SETTINGS      = 5;
  localparam int STALL_LIMIT       = 3000;
  localparam int HOLD_CYCLES       = 300;
  localparam int N_DIRECTED        = 26;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_CLASS, GET_ID, GET_LENGTH, GET_PAYLOAD, GET_CHECKSUM
  } parse_phase_t;

  typedef struct packed {
    logic       good;
    logic       bad;
    logic [7:0] frame_class;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [7:0] frame_checksum;
    logic [7:0] read_data;
  } frame_result_t;

  typedef struct packed {
    logic          cmd;
    logic [7:0]    rx;
    logic [7:0]    ridx;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NONE = '0;

  // default sync bytes 0xAA / 0x55 are in force for this table
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_RECEIVE, 8'h00, 8'hFF, 1'b1, NONE},   // nothing seen yet after reset
    '{CMD_RECEIVE, 8'hAA, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h00, 8'h00, 1'b0, NONE},   // wrong second sync, keeps waiting
    '{CMD_RECEIVE, 8'h55, 8'h80, 1'b0, NONE},
    '{CMD_RECEIVE, 8'hFF, 8'h00, 1'b0, NONE},   // class
    '{CMD_RECEIVE, 8'h00, 8'h00, 1'b0, NONE},   // id
    '{CMD_RECEIVE, 8'h00, 8'h00, 1'b0, NONE},   // zero length still takes one byte
    '{CMD_RECEIVE, 8'hFF, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'hFF, 8'h00, 1'b1,
      '{1'b1, 1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00}},
    '{CMD_READ,    8'h00, 8'h00, 1'b1,
      '{1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF}},
    '{CMD_RECEIVE, 8'hAA, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h55, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h01, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h80, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h02, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h80, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h80, 8'h00, 1'b0, NONE},   // payload sum wraps to zero
    '{CMD_RECEIVE, 8'h01, 8'h00, 1'b1,
      '{1'b0, 1'b1, 8'h01, 8'h80, 8'h02, 8'hFF, 8'h00}},
    '{CMD_READ,    8'hFF, 8'h01, 1'b1,
      '{1'b0, 1'b0, 8'h01, 8'h80, 8'h02, 8'hFF, 8'h80}},
    '{CMD_RECEIVE, 8'hAA, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h55, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h7F, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'hFF, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h01, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h00, 8'h00, 1'b0, NONE},
    '{CMD_RECEIVE, 8'h00, 8'h00, 1'b0, NONE}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // rx_byte, read_index
  logic                  s_tuser;   // command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // class, id, length, checksum, read_data
  logic [OUT_USER_W-1:0] m_tuser;   // frame_good, frame_bad
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  sync_length_checksum_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // parser copy
  logic [7:0]   sync_first_m;
  logic [7:0]   sync_second_m;
  parse_phase_t phase_m;
  logic [7:0]   wpos_m;
  logic [7:0]   length_m;
  logic [7:0]   sum_m;
  logic [7:0]   class_m;
  logic [7:0]   id_m;
  logic [7:0]   cks_m;
  logic [7:0]   store_m [256];
  int           hi_written;

  frame_result_t pending_results[$];
  frame_result_t got_want;
  int            n_sent = 0;
  int            n_errors = 0;
  int            quiet_cycles = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;

  function automatic frame_result_t deframe_step(logic cmd, logic [7:0] rx, logic [7:0] ridx);
    frame_result_t r;
    logic          last;
    r = '0;
    if (cmd == CMD_READ) begin
      r.read_data = store_m[ridx];
    end else begin
      case (phase_m)
        HUNT_FIRST: begin
          if (rx == sync_first_m) phase_m = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          if (rx == sync_second_m) phase_m = GET_CLASS;
        end
        GET_CLASS: begin
          class_m = rx;
          phase_m = GET_ID;
        end
        GET_ID: begin
          id_m = rx;
          phase_m = GET_LENGTH;
        end
        GET_LENGTH: begin
          length_m = rx;
          wpos_m = '0;
          sum_m = '0;
          phase_m = GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          last = ({1'b0, wpos_m} + 9'd1) >= {1'b0, length_m};
          store_m[wpos_m] = rx;
          if (int'(wpos_m) > hi_written) hi_written = int'(wpos_m);
          sum_m = sum_m + rx;
          wpos_m = wpos_m + 8'd1;
          if (last) phase_m = GET_CHECKSUM;
        end
        GET_CHECKSUM: begin
          if (sum_m == rx) begin
            cks_m = rx;
            r.good = 1'b1;
          end else begin
            r.bad = 1'b1;
          end
          phase_m = HUNT_FIRST;
          wpos_m = '0;
          sum_m = '0;
        end
        default: begin
          phase_m = HUNT_FIRST;
          wpos_m = '0;
          sum_m = '0;
        end
      endcase
    end
    r.frame_class    = class_m;
    r.frame_id       = id_m;
    r.frame_length   = length_m;
    r.frame_checksum = cks_m;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // neither side adds random gaps in this window
  function automatic bit calm_window();
    return n_sent >= 600 && n_sent < 800;
  endfunction

  // entered and left at a falling edge
  task automatic drive_item(logic cmd, logic [7:0] rx, logic [7:0] ridx);
    while (!calm_window() && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {ridx, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send(logic cmd, logic [7:0] rx, logic [7:0] ridx);
    pending_results.push_back(deframe_step(cmd, rx, ridx));
    drive_item(cmd, rx, ridx);
  endtask

  // stream byte, now and then preceded by a read of a written store entry
  task automatic put_byte(logic [7:0] b);
    if (hi_written >= 0 && $urandom_range(0, 99) < 8)
      send(CMD_READ, 8'($urandom), 8'($urandom_range(0, hi_written)));
    send(CMD_RECEIVE, b, 8'($urandom));
  endtask

  task automatic send_frame(int forced_len);
    int         len;
    int         nbytes;
    int         pick;
    logic [7:0] b;
    logic [7:0] sum;
    bit         cut;
    // mostly realign first so the frame lands on the header states
    if (forced_len >= 0 || $urandom_range(0, 99) < 85) begin
      while (phase_m != HUNT_FIRST) begin
        case (phase_m)
          HUNT_SECOND: b = sync_second_m;
          GET_LENGTH:  b = 8'($urandom_range(0, 3));
          default:     b = 8'($urandom);
        endcase
        put_byte(b);
      end
    end
    if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    put_byte(sync_first_m);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 2)) begin
        b = 8'($urandom);
        if (b == sync_second_m) b = b ^ 8'h01;
        put_byte(b);
      end
    end
    put_byte(sync_second_m);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    pick = $urandom_range(0, 99);
    if (forced_len >= 0) len = forced_len;
    else if (pick < 88) len = $urandom_range(0, 8);
    else if (pick < 99) len = $urandom_range(9, 40);
    else len = $urandom_range(100, 255);
    put_byte(8'(len));
    nbytes = (len == 0) ? 1 : len;
    sum = '0;
    cut = forced_len < 0 && $urandom_range(0, 99) < 6;
    for (int k = 0; k < nbytes; k++) begin
      if (cut && $urandom_range(0, 3) == 0) return;
      b = 8'($urandom);
      sum = sum + b;
      put_byte(b);
    end
    if ($urandom_range(0, 99) < 75) put_byte(sum);
    else put_byte(sum ^ 8'($urandom_range(1, 255)));
  endtask

  // setup + access write, then read back
  task automatic reg_write(logic idx, logic [7:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("prdata", val, prdata[7:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (idx == REG_SYNC_FIRST) sync_first_m = val;
    else sync_second_m = val;
  endtask

  initial begin
    frame_result_t want;
    logic [7:0]    sf;
    logic [7:0]    ss;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_RECEIVE;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    sync_first_m  = SYNC_FIRST_RESET;
    sync_second_m = SYNC_SECOND_RESET;
    phase_m    = HUNT_FIRST;
    wpos_m     = '0;
    length_m   = '0;
    sum_m      = '0;
    class_m    = '0;
    id_m       = '0;
    cks_m      = '0;
    hi_written = -1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      want = deframe_step(DIRECTED[i].cmd, DIRECTED[i].rx, DIRECTED[i].ridx);
      if (DIRECTED[i].typed) want = DIRECTED[i].want;
      pending_results.push_back(want);
      drive_item(DIRECTED[i].cmd, DIRECTED[i].rx, DIRECTED[i].ridx);
    end

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph != 0) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        case (ph)
          1: begin sf = 8'h00; ss = 8'hFF; end
          2: begin sf = 8'hFF; ss = 8'h00; end
          3: begin sf = 8'($urandom); ss = 8'($urandom); end
          default: begin sf = 8'($urandom); ss = sf; end   // identical sync bytes
        endcase
        reg_write(REG_SYNC_FIRST, sf);
        reg_write(REG_SYNC_SECOND, ss);
      end
      if (ph == 2) send_frame(255);
      while (n_sent < N_DIRECTED + (ph + 1) * ITEMS_PER_SETTING) send_frame(-1);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && n_sent >= 400) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm_window() || $urandom_range(0, 99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        n_errors++;
      end else begin
        got_want = pending_results.pop_front();
        check_field("frame_good", 8'(got_want.good), 8'(m_tuser[TUSER_GOOD]));
        check_field("frame_bad", 8'(got_want.bad), 8'(m_tuser[TUSER_BAD]));
        check_field("frame_class", got_want.frame_class, m_tdata[7:0]);
        check_field("frame_id", got_want.frame_id, m_tdata[15:8]);
        check_field("frame_length", got_want.frame_length, m_tdata[23:16]);
        check_field("frame_checksum", got_want.frame_checksum, m_tdata[31:24]);
        check_field("read_data", got_want.read_data, m_tdata[39:32]);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

/* sync_length_checksum_deframer.f */
+incdir+src
src/slcd_pkg.sv
src/slcd_payload_ram.sv
src/sync_length_checksum_deframer.sv
src/slcd_checker.sv
verif/tb_top.sv
